FILE: sv/utfv_pkg.sv
package utfv_pkg;

  // longest string the count is sized for; the count saturates at this
  localparam int MaxBytes = 65536;
  localparam int CountW   = 17;
  localparam logic [CountW-1:0] CountMax =
    CountW'((MaxBytes > 131071) ? 131071 : MaxBytes);

  localparam int AccW   = 21;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_CONT     = 3'd2,
    ERR_OVERLONG = 3'd3,
    ERR_SURR     = 3'd4,
    ERR_RANGE    = 3'd5,
    ERR_LEAD     = 3'd6
  } err_code_t;

  typedef enum logic [2:0] {
    BK_ASCII,
    BK_LEAD2,
    BK_LEAD3,
    BK_LEAD4,
    BK_BAD
  } byte_kind_t;

  // one classified byte, as it travels through the queue
  typedef struct packed {
    byte_kind_t  kind;       // meaning of the byte in a lead position
    logic        cont_ok;    // byte is 10xxxxxx
    logic [4:0]  lead_bits;  // payload bits of a lead byte, already masked
    logic [5:0]  cont_bits;  // payload bits of a continuation byte
    logic        last;
  } utfv_item_t;

endpackage

FILE: sv/utfv_front.sv
module utfv_front import utfv_pkg::*; (
  input  logic       in_valid,
  input  logic       q_full,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       push,
  output utfv_item_t item
);

  assign push = in_valid & ~q_full;

  always_comb begin
    item.kind      = BK_BAD;
    item.lead_bits = 5'd0;
    item.cont_ok   = (data_byte[7:6] == 2'b10);
    item.cont_bits = data_byte[5:0];
    item.last      = last;
    case (data_byte) inside
      8'b0???_????: begin
        item.kind = BK_ASCII;
      end
      8'b110?_????: begin
        item.kind      = BK_LEAD2;
        item.lead_bits = data_byte[4:0];
      end
      8'b1110_????: begin
        item.kind      = BK_LEAD3;
        item.lead_bits = {1'b0, data_byte[3:0]};
      end
      8'b1111_0???: begin
        item.kind      = BK_LEAD4;
        item.lead_bits = {2'b00, data_byte[2:0]};
      end
      default: begin
        item.kind = BK_BAD;
      end
    endcase
  end

endmodule

FILE: sv/utfv_queue.sv
module utfv_queue import utfv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  utfv_item_t push_item,
  input  logic       pop,
  output utfv_item_t pop_item,
  output logic       full,
  output logic       not_empty
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  utfv_item_t            mem_r [QDepth];
  logic [PtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/utfv_back.sv
module utfv_back import utfv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  utfv_item_t        item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              valid_res,
  output logic [CountW-1:0] char_count,
  output logic [2:0]        error_code
);

  logic [1:0]        pend_r, pend_nxt;
  logic [1:0]        seq_r, seq_nxt;
  logic [AccW-1:0]   acc_r, acc_nxt;
  logic              bad_r, bad_nxt;
  logic [CountW-1:0] tot_r, tot_nxt;
  err_code_t         err_r, err_nxt;

  logic              ov_r, ov_nxt;
  logic              ok_r;
  logic [CountW-1:0] cnt_r;
  err_code_t         res_err_r;

  err_code_t         fin_err;
  logic [CountW-1:0] fin_cnt;
  err_code_t         chk;
  logic [CountW-1:0] tot_inc;

  // verdict on a completed multi-byte sequence
  function automatic err_code_t seq_check(input logic [1:0] len,
                                          input logic [AccW-1:0] cp,
                                          input logic bad);
    err_code_t e;
    e = ERR_NONE;
    if (bad) begin
      e = ERR_CONT;
    end else if (len == 2'd1) begin
      if (cp < AccW'(32'h80)) e = ERR_OVERLONG;
    end else if (len == 2'd2) begin
      if (cp < AccW'(32'h800)) begin
        e = ERR_OVERLONG;
      end else if (cp >= AccW'(32'hD800) && cp <= AccW'(32'hDFFF)) begin
        e = ERR_SURR;
      end
    end else begin
      if (cp < AccW'(32'h10000)) begin
        e = ERR_OVERLONG;
      end else if (cp > AccW'(32'h10FFFF)) begin
        e = ERR_RANGE;
      end
    end
    return e;
  endfunction

  assign pop      = q_not_empty & (~ov_r | ~out_stall);
  assign tot_inc  = (tot_r < CountMax) ? tot_r + CountW'(1) : tot_r;

  always_comb begin
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    acc_nxt  = acc_r;
    bad_nxt  = bad_r;
    tot_nxt  = tot_r;
    err_nxt  = err_r;
    chk      = ERR_NONE;
    fin_err  = ERR_NONE;
    fin_cnt  = tot_r;
    ov_nxt   = ov_r & out_stall;
    if (pop) begin
      if (err_r == ERR_NONE) begin
        if (pend_r != 2'd0) begin
          bad_nxt  = bad_r | ~item.cont_ok;
          acc_nxt  = {acc_r[AccW-7:0], item.cont_bits};
          pend_nxt = pend_r - 2'd1;
          if (pend_nxt == 2'd0) begin
            chk = seq_check(seq_r, acc_nxt, bad_nxt);
            if (chk != ERR_NONE) begin
              err_nxt = chk;
            end else begin
              tot_nxt = tot_inc;
            end
          end
        end else begin
          case (item.kind)
            BK_ASCII: begin
              tot_nxt = tot_inc;
            end
            BK_LEAD2: begin
              seq_nxt  = 2'd1;
              pend_nxt = 2'd1;
              acc_nxt  = AccW'(item.lead_bits);
              bad_nxt  = 1'b0;
            end
            BK_LEAD3: begin
              seq_nxt  = 2'd2;
              pend_nxt = 2'd2;
              acc_nxt  = AccW'(item.lead_bits);
              bad_nxt  = 1'b0;
            end
            BK_LEAD4: begin
              seq_nxt  = 2'd3;
              pend_nxt = 2'd3;
              acc_nxt  = AccW'(item.lead_bits);
              bad_nxt  = 1'b0;
            end
            default: begin
              err_nxt = ERR_LEAD;
            end
          endcase
        end
      end
      fin_err = (err_nxt == ERR_NONE && pend_nxt != 2'd0) ? ERR_TRUNC : err_nxt;
      // count including this beat, taken before the string state is cleared
      fin_cnt = tot_nxt;
      if (item.last) begin
        ov_nxt   = 1'b1;
        pend_nxt = '0;
        seq_nxt  = '0;
        acc_nxt  = '0;
        bad_nxt  = 1'b0;
        tot_nxt  = '0;
        err_nxt  = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seq_r  <= '0;
      acc_r  <= '0;
      bad_r  <= 1'b0;
      tot_r  <= '0;
      err_r  <= ERR_NONE;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      seq_r  <= seq_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      tot_r  <= tot_nxt;
      err_r  <= err_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      ok_r      <= (fin_err == ERR_NONE);
      cnt_r     <= fin_cnt;
      res_err_r <= fin_err;
    end
  end

  assign out_valid  = ov_r;
  assign valid_res  = ok_r;
  assign char_count = cnt_r;
  assign error_code = res_err_r;

  a_pend_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= seq_r) else $error("pending bytes exceed open sequence");

  a_no_trunc_latched: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_TRUNC) else $error("truncation latched mid string");

  a_flag_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ok_r == (res_err_r == ERR_NONE)))
    else $error("valid flag disagrees with error code");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= CountMax) else $error("character count beyond cap");

  a_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && item.last) |=> (pend_r == 2'd0 && err_r == ERR_NONE && tot_r == '0))
    else $error("string state not cleared after last beat");

endmodule

FILE: sv/utf8_validate_and_count.sv
// channel  direction  ports                                   beat taken when
// in       input      in_valid in_stall in_data_byte in_last  in_valid & !in_stall
// out      output     out_valid out_stall out_valid_res       out_valid & !out_stall
//                     out_char_count out_error_code
//
// one byte per cycle sustained while out_stall holds no pending result; a
// byte is queued, then popped into the decode state, and the result of a
// string appears on the cycle after its last byte leaves the two-entry queue
// the queue depth sets how many bytes are taken while the result register
// waits on out_stall; in_stall rises only when the queue is full
// synchronous active-low reset empties the queue and clears string state
module utf8_validate_and_count import utfv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_valid_res,
  output logic [CountW-1:0] out_char_count,
  output logic [2:0]        out_error_code
);

  // classified byte and queue handshake
  utfv_item_t front_item;
  utfv_item_t back_item;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;

  assign in_stall = q_full;

  // front: sort each byte into lead kind and payload bits
  utfv_front u_front (
    .in_valid  (in_valid),
    .q_full    (q_full),
    .data_byte (in_data_byte),
    .last      (in_last),
    .push      (push),
    .item      (front_item)
  );

  // short queue between classification and decode
  utfv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (back_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // back: sequence tracking, error latch, count and result register
  utfv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .item        (back_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (out_valid_res),
    .char_count  (out_char_count),
    .error_code  (out_error_code)
  );

endmodule
